[design/rkpq_pkg.sv]
// rkpq_pkg: shared constants, operation codes, sequencer state and control
// types for the rank keyed priority queue. No dependencies.
package rkpq_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_W  = 4;
  localparam int PRIO_W  = 31;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 38;
  localparam int MASK_W  = 16;
  localparam int FUNC_W  = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 3'd0,
    FN_POP   = 3'd1,
    FN_SUB   = 3'd2,
    FN_DEL   = 3'd3,
    FN_QUERY = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HSCAN,
    S_HDRAIN,
    S_POPCLR,
    S_RDRANK,
    S_MODIFY,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // sequencer controls towards the datapath
  typedef struct packed {
    logic              busy;
    logic              issue;     // scan read issued at addr
    logic [SLOT_W-1:0] addr;
    logic              elem_vld;  // read data of a scan slot is on the RAM outputs
    logic [SLOT_W-1:0] elem_idx;
    logic              rd_rank;   // read the addressed rank
    logic              modify;    // apply the operation to the addressed rank
    logic              pop_clr;   // drop the head found by the first scan
    logic              scan_clr;
    logic              finish;    // load the result registers
  } ctl_t;

  // a is ordered strictly before b
  function automatic logic ahead(input logic [PRIO_W-1:0] pa, input logic [SLOT_W-1:0] ia,
                                 input logic [PRIO_W-1:0] pb, input logic [SLOT_W-1:0] ib);
    ahead = (pa < pb) || ((pa == pb) && (ia < ib));
  endfunction

endpackage

[design/rkpq_ram.sv]
// rkpq_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module rkpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/rkpq_scan.sv]
// rkpq_scan: compare and accumulate unit fed one slot per cycle; tracks the
// best entry and the sum of values ordered at or before the key (of all values if the key is absent). Uses rkpq_pkg.
module rkpq_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          en,
  input  logic [rkpq_pkg::SLOT_W-1:0]   idx,
  input  logic [rkpq_pkg::PRIO_W-1:0]   prio,
  input  logic [rkpq_pkg::VAL_W-1:0]    value,
  input  logic                          key_present,
  input  logic [rkpq_pkg::PRIO_W-1:0]   key_prio,
  input  logic [rkpq_pkg::SLOT_W-1:0]   key_idx,
  output logic                          best_found,
  output logic [rkpq_pkg::SLOT_W-1:0]   best_idx,
  output logic signed [rkpq_pkg::SUM_W-1:0] sum
);

  logic                                 found_r, found_nxt;
  logic [rkpq_pkg::SLOT_W-1:0]          bidx_r, bidx_nxt;
  logic [rkpq_pkg::PRIO_W-1:0]          bprio_r, bprio_nxt;
  logic signed [rkpq_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                                 take_best, take_sum;

  always_comb begin
    take_best = !found_r || rkpq_pkg::ahead(prio, idx, bprio_r, bidx_r);
    take_sum  = !key_present || !rkpq_pkg::ahead(key_prio, key_idx, prio, idx);
    found_nxt = found_r;
    bidx_nxt  = bidx_r;
    bprio_nxt = bprio_r;
    sum_nxt   = sum_r;
    if (clr) begin
      found_nxt = 1'b0;
      sum_nxt   = '0;
    end else if (en) begin
      if (take_best) begin
        found_nxt = 1'b1;
        bidx_nxt  = idx;
        bprio_nxt = prio;
      end
      if (take_sum) begin
        sum_nxt = sum_r + rkpq_pkg::SUM_W'(signed'(value));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    bidx_r  <= bidx_nxt;
    bprio_r <= bprio_nxt;
    sum_r   <= sum_nxt;
  end

  assign best_found = found_r;
  assign best_idx   = bidx_r;
  assign sum        = sum_r;

endmodule

[design/rkpq_seq.sv]
// rkpq_seq: sequencer for the queue; walks the slots once per scan and
// issues the modify, pop and result steps. Uses rkpq_pkg.
module rkpq_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           pop_req,
  output rkpq_pkg::ctl_t ctl
);

  localparam logic [rkpq_pkg::SLOT_W-1:0] LAST = rkpq_pkg::SLOT_W'(rkpq_pkg::SLOTS - 1);

  rkpq_pkg::state_t              state_r, state_nxt;
  logic [rkpq_pkg::SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic                          evld_r, evld_nxt;
  logic [rkpq_pkg::SLOT_W-1:0]   eidx_r;
  logic                          issue;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rkpq_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = pop_req ? rkpq_pkg::S_HSCAN : rkpq_pkg::S_RDRANK;
        end
      end
      rkpq_pkg::S_HSCAN: begin
        if (cnt_r == LAST) begin
          state_nxt = rkpq_pkg::S_HDRAIN;
        end
      end
      rkpq_pkg::S_HDRAIN: state_nxt = rkpq_pkg::S_POPCLR;
      rkpq_pkg::S_POPCLR: state_nxt = rkpq_pkg::S_RDRANK;
      rkpq_pkg::S_RDRANK: state_nxt = rkpq_pkg::S_MODIFY;
      rkpq_pkg::S_MODIFY: state_nxt = rkpq_pkg::S_SCAN;
      rkpq_pkg::S_SCAN: begin
        if (cnt_r == LAST) begin
          state_nxt = rkpq_pkg::S_DRAIN;
        end
      end
      rkpq_pkg::S_DRAIN:  state_nxt = rkpq_pkg::S_DONE;
      rkpq_pkg::S_DONE:   state_nxt = rkpq_pkg::S_IDLE;
      default:            state_nxt = rkpq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue        = (state_r == rkpq_pkg::S_HSCAN) || (state_r == rkpq_pkg::S_SCAN);
    ctl          = '0;
    ctl.busy     = (state_r != rkpq_pkg::S_IDLE);
    ctl.issue    = issue;
    ctl.addr     = cnt_r;
    ctl.elem_vld = evld_r;
    ctl.elem_idx = eidx_r;
    ctl.rd_rank  = (state_r == rkpq_pkg::S_RDRANK);
    ctl.modify   = (state_r == rkpq_pkg::S_MODIFY);
    ctl.pop_clr  = (state_r == rkpq_pkg::S_POPCLR);
    ctl.scan_clr = ((state_r == rkpq_pkg::S_IDLE) && start) ||
                   (state_r == rkpq_pkg::S_MODIFY);
    ctl.finish   = (state_r == rkpq_pkg::S_DONE);
    cnt_nxt      = cnt_r;
    if (issue) begin
      cnt_nxt = (cnt_r == LAST) ? '0 : cnt_r + 1'b1;
    end
    evld_nxt     = issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rkpq_pkg::S_IDLE;
      cnt_r   <= '0;
      evld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      evld_r  <= evld_nxt;
    end
    eidx_r <= cnt_r;
  end

endmodule

[design/rank_keyed_priority_queue.sv]
// rank_keyed_priority_queue: top level; request registers, valid bits,
// priority and value RAMs, scan unit and sequencer. Uses rkpq_pkg, rkpq_ram,
// rkpq_scan, rkpq_seq.
//
//   channel   handshake          payload
//   request   start / busy       in_func, in_rank, in_priority_req, in_amount
//   result    out_valid strobe   out_queue_empty, out_head_rank, out_rank_priority,
//                                out_values_ahead, out_waiting_mask
//
// A request makes one pass over the slots and a pop two: each pass reads one
// entry per cycle from the single-read-port RAMs.
// The result strobe is up in the first cycle with busy low; a new request may be
// taken in that same cycle. The receiver cannot stall; results are held on
// the ports until the next one. Reset clears the valid bits, no RAM pass.
module rank_keyed_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rkpq_pkg::FUNC_W-1:0]         in_func,
  input  logic [rkpq_pkg::RANK_W-1:0]         in_rank,
  input  logic [rkpq_pkg::PRIO_W-1:0]         in_priority_req,
  input  logic signed [rkpq_pkg::VAL_W-1:0]   in_amount,
  output logic                                out_valid,
  output logic                                out_queue_empty,
  output logic [rkpq_pkg::RANK_W-1:0]         out_head_rank,
  output logic [rkpq_pkg::PRIO_W-1:0]         out_rank_priority,
  output logic signed [rkpq_pkg::SUM_W-1:0]   out_values_ahead,
  output logic [rkpq_pkg::MASK_W-1:0]         out_waiting_mask
);

  localparam int VEXT_W = (rkpq_pkg::SLOTS > rkpq_pkg::MASK_W) ?
                          rkpq_pkg::SLOTS : rkpq_pkg::MASK_W;

  rkpq_pkg::ctl_t                     ctl;
  logic                               accept;

  logic [rkpq_pkg::FUNC_W-1:0]        func_r;
  logic [rkpq_pkg::RANK_W-1:0]        rank_r;
  logic [rkpq_pkg::PRIO_W-1:0]        prio_r;
  logic [rkpq_pkg::VAL_W-1:0]         amt_r;
  logic [rkpq_pkg::PRIO_W-1:0]        key_prio_r, key_prio_nxt;

  logic [rkpq_pkg::SLOTS-1:0]         valid_r, valid_nxt;
  logic [rkpq_pkg::SLOT_W-1:0]        slot;
  logic                               in_range, present;

  logic                               prio_we, val_we;
  logic [rkpq_pkg::VAL_W-1:0]         val_wdata, val_diff;
  logic [rkpq_pkg::SLOT_W-1:0]        raddr;
  logic [rkpq_pkg::PRIO_W-1:0]        prio_rdata;
  logic [rkpq_pkg::VAL_W-1:0]         val_rdata;

  logic                               best_found;
  logic [rkpq_pkg::SLOT_W-1:0]        best_idx;
  logic signed [rkpq_pkg::SUM_W-1:0]  sum;
  logic [VEXT_W-1:0]                  vext;

  logic                               ov_r;
  logic                               empty_r;
  logic [rkpq_pkg::RANK_W-1:0]        head_r;
  logic [rkpq_pkg::PRIO_W-1:0]        rprio_r;
  logic signed [rkpq_pkg::SUM_W-1:0]  sum_r;
  logic [rkpq_pkg::MASK_W-1:0]        mask_r;

  assign busy   = ctl.busy;
  assign accept = start && !ctl.busy;

  rkpq_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .pop_req (in_func == rkpq_pkg::FN_POP),
    .ctl     (ctl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      rank_r <= in_rank;
      prio_r <= in_priority_req;
      amt_r  <= in_amount;
    end
  end

  assign slot     = rkpq_pkg::SLOT_W'(rank_r);
  assign in_range = int'(rank_r) < rkpq_pkg::SLOTS;
  assign present  = in_range && valid_r[slot];
  assign raddr    = ctl.rd_rank ? slot : ctl.addr;
  assign val_diff = val_rdata - amt_r;

  // drop the popped head on pop_clr; apply the operation to the addressed rank; RAM data from the rank read
  always_comb begin
    valid_nxt    = valid_r;
    prio_we      = 1'b0;
    val_we       = 1'b0;
    val_wdata    = amt_r;
    key_prio_nxt = key_prio_r;
    if (ctl.pop_clr && best_found) begin
      valid_nxt[best_idx] = 1'b0;
    end
    if (ctl.modify) begin
      key_prio_nxt = prio_rdata;
      case (func_r)
        rkpq_pkg::FN_PUSH: begin
          key_prio_nxt = prio_r;
          if (in_range) begin
            prio_we         = 1'b1;
            val_we          = 1'b1;
            valid_nxt[slot] = 1'b1;
          end
        end
        rkpq_pkg::FN_SUB: begin
          if (present) begin
            val_we    = 1'b1;
            val_wdata = val_diff;
            if (val_diff == '0) begin
              valid_nxt[slot] = 1'b0;
            end
          end
        end
        rkpq_pkg::FN_DEL: begin
          if (in_range) begin
            valid_nxt[slot] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_prio_r <= key_prio_nxt;
  end

  rkpq_ram #(.WIDTH(rkpq_pkg::PRIO_W), .DEPTH(rkpq_pkg::SLOTS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (slot),
    .wdata (prio_r),
    .raddr (raddr),
    .rdata (prio_rdata)
  );

  rkpq_ram #(.WIDTH(rkpq_pkg::VAL_W), .DEPTH(rkpq_pkg::SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  rkpq_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (ctl.scan_clr),
    .en          (ctl.elem_vld && valid_r[ctl.elem_idx]),
    .idx         (ctl.elem_idx),
    .prio        (prio_rdata),
    .value       (val_rdata),
    .key_present (present),
    .key_prio    (key_prio_r),
    .key_idx     (slot),
    .best_found  (best_found),
    .best_idx    (best_idx),
    .sum         (sum)
  );

  assign vext = VEXT_W'(valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ctl.finish;
    end
    if (ctl.finish) begin
      empty_r <= !best_found;
      head_r  <= best_found ? rkpq_pkg::RANK_W'(best_idx) : '0;
      rprio_r <= present ? key_prio_r : '0;
      sum_r   <= sum;
      mask_r  <= vext[rkpq_pkg::MASK_W-1:0];
    end
  end

  assign out_valid         = ov_r;
  assign out_queue_empty   = empty_r;
  assign out_head_rank     = head_r;
  assign out_rank_priority = rprio_r;
  assign out_values_ahead  = sum_r;
  assign out_waiting_mask  = mask_r;

endmodule

[design/rkpq_checker.sv]
// rkpq_checker: port-level checks for rank_keyed_priority_queue, bound to
// the top level. Uses rkpq_pkg.
module rkpq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_queue_empty,
  input logic [rkpq_pkg::RANK_W-1:0]        out_head_rank,
  input logic [rkpq_pkg::MASK_W-1:0]        out_waiting_mask
);

  // every request gets the block busy
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken without busy");

  // a result closes a busy stretch
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy)) else $error("result strobe out of place");

  a_res_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queue_empty == (out_waiting_mask == '0)))
    else $error("empty flag disagrees with mask");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_empty |-> out_head_rank == '0)
    else $error("head rank set on empty queue");

endmodule

bind rank_keyed_priority_queue rkpq_checker u_rkpq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_queue_empty  (out_queue_empty),
  .out_head_rank    (out_head_rank),
  .out_waiting_mask (out_waiting_mask)
);

[sim/tb_rank_keyed_priority_queue.sv]
// Self-checking testbench for rank_keyed_priority_queue: directed and random requests,
// predicted results checked in order by a scoreboard class.
// Depends on rkpq_pkg and the rank_keyed_priority_queue RTL.
`timescale 1ns / 1ps

module tb_rank_keyed_priority_queue;
  import rkpq_pkg::*;

  localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};
  localparam logic [VAL_W-1:0]  VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  VAL_MIN  = 32'h8000_0000;
  localparam int                QUIET_FROM = 1300;
  localparam int                TOTAL_REQS = 1600;

  typedef struct packed {
    logic              empty;
    logic [RANK_W-1:0] head;
    logic [PRIO_W-1:0] prio;
    logic [SUM_W-1:0]  sum;
    logic [MASK_W-1:0] mask;
  } status_t;

  class queue_scoreboard;
    bit                slot_valid[SLOTS];
    logic [PRIO_W-1:0] slot_prio[SLOTS];
    logic [VAL_W-1:0]  slot_val[SLOTS];
    status_t           expected_status[$];
    int                errors;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      errors = 0;
    endfunction

    // entry a is served strictly before entry b
    function bit served_first(int a, int b);
      if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
      return a < b;
    endfunction

    function int head_slot();
      int best;
      best = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && (best == SLOTS || served_first(i, best))) best = i;
      end
      return best;
    endfunction

    function void note_request(logic [FUNC_W-1:0] fn, logic [RANK_W-1:0] rk,
                               logic [PRIO_W-1:0] pr, logic [VAL_W-1:0] amt);
      int      hd;
      bit      present;
      status_t st;
      case (fn)
        FN_PUSH: begin
          slot_valid[rk] = 1'b1;
          slot_prio[rk]  = pr;
          slot_val[rk]   = amt;
        end
        FN_POP: begin
          hd = head_slot();
          if (hd < SLOTS) slot_valid[hd] = 1'b0;
        end
        FN_SUB: begin
          if (slot_valid[rk]) begin
            slot_val[rk] = slot_val[rk] - amt;
            if (slot_val[rk] == '0) slot_valid[rk] = 1'b0;
          end
        end
        FN_DEL: slot_valid[rk] = 1'b0;
        default: ;  // query and unknown codes change nothing
      endcase

      hd      = head_slot();
      present = slot_valid[rk];
      st      = '0;
      st.empty = (hd == SLOTS);
      st.head  = (hd == SLOTS) ? '0 : RANK_W'(hd);
      st.prio  = present ? slot_prio[rk] : '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_valid[i]) continue;
        st.mask[i] = 1'b1;
        // absent rank: sum covers every entry
        if (!present || !served_first(rk, i))
          st.sum = st.sum + {{(SUM_W-VAL_W){slot_val[i][VAL_W-1]}}, slot_val[i]};
      end
      expected_status.push_back(st);
    endfunction

    function void check_status(status_t got);
      status_t exp;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: %h", $time, got);
        return;
      end
      exp = expected_status.pop_front();
      if (got == exp) return;
      errors++;
      if (got.empty != exp.empty)
        $display("%0t: queue_empty exp %0b got %0b", $time, exp.empty, got.empty);
      if (got.head != exp.head)
        $display("%0t: head_rank exp %0d got %0d", $time, exp.head, got.head);
      if (got.prio != exp.prio)
        $display("%0t: rank_priority exp %0d got %0d", $time, exp.prio, got.prio);
      if (got.sum != exp.sum)
        $display("%0t: values_ahead exp %0d got %0d", $time,
                 $signed(exp.sum), $signed(got.sum));
      if (got.mask != exp.mask)
        $display("%0t: waiting_mask exp %h got %h", $time, exp.mask, got.mask);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [FUNC_W-1:0]        in_func;
  logic [RANK_W-1:0]        in_rank;
  logic [PRIO_W-1:0]        in_priority_req;
  logic signed [VAL_W-1:0]  in_amount;
  logic                     out_valid;
  logic                     out_queue_empty;
  logic [RANK_W-1:0]        out_head_rank;
  logic [PRIO_W-1:0]        out_rank_priority;
  logic signed [SUM_W-1:0]  out_values_ahead;
  logic [MASK_W-1:0]        out_waiting_mask;

  queue_scoreboard sb;
  int              sent;

  rank_keyed_priority_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_rank           (in_rank),
    .in_priority_req   (in_priority_req),
    .in_amount         (in_amount),
    .out_valid         (out_valid),
    .out_queue_empty   (out_queue_empty),
    .out_head_rank     (out_head_rank),
    .out_rank_priority (out_rank_priority),
    .out_values_ahead  (out_values_ahead),
    .out_waiting_mask  (out_waiting_mask)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_status({out_queue_empty, out_head_rank, out_rank_priority,
                       out_values_ahead, out_waiting_mask});
  end

  // start stays high across back-to-back requests
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [RANK_W-1:0] rk,
                              input logic [PRIO_W-1:0] pr, input logic [VAL_W-1:0] amt);
    start           <= 1'b1;
    in_func         <= fn;
    in_rank         <= rk;
    in_priority_req <= pr;
    in_amount       <= amt;
    do @(posedge clk); while (busy);
    sb.note_request(fn, rk, pr, amt);
    sent++;
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    if (sb.expected_status.size() != 0) begin
      start <= 1'b0;
      while (sb.expected_status.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return PRIO_W'($urandom_range(0, 7));  // frequent ties
      5:             return '0;
      6:             return PRIO_MAX;
      default:       return PRIO_W'($urandom());
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return VAL_W'($urandom_range(0, 16)) - 32'd8;
      4:          return '0;
      5:          return VAL_MAX;
      6:          return VAL_MIN;
      default:    return VAL_W'($urandom());
    endcase
  endfunction

  task automatic random_request();
    int                pick;
    logic [FUNC_W-1:0] fn;
    logic [RANK_W-1:0] rk;
    logic [VAL_W-1:0]  amt;
    pick = $urandom_range(0, 99);
    rk   = RANK_W'($urandom_range(0, SLOTS - 1));
    amt  = pick_amount();
    if (pick < 35)      fn = FN_PUSH;
    else if (pick < 50) fn = FN_POP;
    else if (pick < 70) fn = FN_SUB;
    else if (pick < 80) fn = FN_DEL;
    else if (pick < 95) fn = FN_QUERY;
    else                fn = FUNC_W'($urandom_range(5, 7));
    // mostly address a rank that holds an entry
    if (fn != FN_PUSH && $urandom_range(0, 3) != 0) begin
      for (int t = 0; t < 16 && !sb.slot_valid[rk]; t++)
        rk = RANK_W'($urandom_range(0, SLOTS - 1));
    end
    if (fn == FN_SUB && sb.slot_valid[rk] && $urandom_range(0, 1) == 1)
      amt = sb.slot_val[rk];  // drains the entry to zero
    send_request(fn, rk, pick_priority(), amt);
  endtask

  // every rank with the same extreme value, then queries and a full drain
  task automatic fill_and_drain();
    logic [VAL_W-1:0] v;
    v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    for (int r = 0; r < SLOTS; r++)
      send_request(FN_PUSH, RANK_W'(r), pick_priority(), v);
    repeat (3) send_request(FN_QUERY, RANK_W'($urandom_range(0, SLOTS - 1)), '0, '0);
    repeat (SLOTS + 1) send_request(FN_POP, RANK_W'($urandom()), PRIO_W'($urandom()),
                                    VAL_W'($urandom()));
  endtask

  initial begin
    sb              = new();
    sent            = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_func         <= FN_QUERY;
    in_rank         <= '0;
    in_priority_req <= '0;
    in_amount       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(FN_QUERY, 4'd0, '0, '0);
    send_request(FN_POP, 4'd3, '0, '0);       // pop on empty queue
    send_request(FN_SUB, 4'd5, '0, 32'd1);    // absent rank
    send_request(FN_DEL, 4'd5, '0, '0);
    send_request(FN_PUSH, 4'd15, PRIO_MAX, VAL_MAX);
    send_request(FN_PUSH, 4'd0, '0, VAL_MIN);
    send_request(FN_PUSH, 4'd7, '0, '0);      // priority tie, zero value kept
    send_request(FN_QUERY, 4'd7, '0, '0);
    send_request(FN_PUSH, 4'd15, 31'd5, 32'd1);  // replace
    send_request(FN_SUB, 4'd15, '0, 32'd1);   // reaches zero, removed
    send_request(FN_SUB, 4'd0, '0, 32'd1);    // wraps
    send_request(FN_SUB, 4'd7, '0, '0);       // zero stays zero, removed
    send_request(3'd5, 4'd0, '0, '0);
    send_request(3'd6, 4'd0, '0, '0);
    send_request(3'd7, 4'd0, '0, '0);
    send_request(FN_PUSH, 4'd9, PRIO_MAX, 32'hFFFF_FFFF);
    send_request(FN_QUERY, 4'd9, PRIO_MAX, 32'hFFFF_FFFF);
    send_request(FN_DEL, 4'd0, '0, '0);
    send_request(FN_POP, 4'd0, '0, '0);
    send_request(FN_POP, 4'd0, '0, '0);
    wait_drained();

    while (sent < TOTAL_REQS) begin
      if (sent < QUIET_FROM && (sent / 100) % 3 != 2 && $urandom_range(0, 3) == 0)
        idle($urandom_range(1, 9));
      if (sent % 500 < 3 && sent > 100)
        wait_drained();
      if ($urandom_range(0, 149) == 0)
        fill_and_drain();
      else
        random_request();
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
